[hw/rtl/gf2_polynomial_alu_defines.svh]
// Assertion macros for the GF(2) polynomial ALU.
`ifndef GF2_POLYNOMIAL_ALU_DEFINES_SVH
`define GF2_POLYNOMIAL_ALU_DEFINES_SVH

`ifndef ASSERT_OFF

`define GF2PA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gf2pa check failed");

`define GF2PA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gf2pa check failed");

`else

`define GF2PA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)

`define GF2PA_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/gf2pa_pkg.sv]
package gf2pa_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = 6;
    localparam int CELL_W  = 2 * MAX_LEN - 1;

    localparam logic [2:0] CMD_MUL = 3'd0;
    localparam logic [2:0] CMD_QUO = 3'd1;
    localparam logic [2:0] CMD_REM = 3'd2;
    localparam logic [2:0] CMD_GCD = 3'd3;
    localparam logic [2:0] CMD_LCM = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DIV_TOP = 2'd1;
    localparam logic [1:0] STAT_SHORT   = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [MAX_LEN-1:0] first_coeffs;
        logic [LEN_W-1:0]   first_len;
        logic [MAX_LEN-1:0] second_coeffs;
        logic [LEN_W-1:0]   second_len;
    } in_word_t;

    typedef struct packed {
        logic [CELL_W-1:0] result_coeffs;
        logic [LEN_W-1:0]  result_len;
        logic [1:0]        status;
    } out_word_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LOAD_CS,
        CELL_MUL,
        CELL_SHIFT_UP,
        CELL_REDUCE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     t_bit;
        logic     a_bit;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIM,
        ST_CHECK,
        ST_ALIGN,
        ST_REDUCE,
        ST_TRIMR,
        ST_SWAP,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_R,
        SRC_Q
    } src_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0)
            res = LEN_W'(1);
        else if (len > LEN_W'(MAX_LEN))
            res = LEN_W'(MAX_LEN);
        else
            res = len;
        return res;
    endfunction

    function automatic logic [MAX_LEN-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [MAX_LEN-1:0] m;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

endpackage

[hw/rtl/gf2pa_cell.sv]
module gf2pa_cell (
    input  logic                  clk,
    input  gf2pa_pkg::cell_ctl_t  ctl,
    input  logic                  ld_r,
    input  logic                  ld_cs,
    input  logic                  r_lo,
    input  logic                  cs_lo,
    input  logic                  cs_hi,
    input  logic                  q_lo,
    output logic                  r,
    output logic                  cs,
    output logic                  q
);

    logic r_reg, r_next;
    logic cs_reg, cs_next;
    logic q_reg, q_next;

    always_comb
    begin
        r_next  = r_reg;
        cs_next = cs_reg;
        q_next  = q_reg;
        case (ctl.op)
            gf2pa_pkg::CELL_HOLD:
            begin
            end
            gf2pa_pkg::CELL_LOAD:
            begin
                r_next  = ld_r;
                cs_next = ld_cs;
                q_next  = 1'b0;
            end
            gf2pa_pkg::CELL_LOAD_CS:
            begin
                cs_next = ld_cs;
                q_next  = 1'b0;
            end
            gf2pa_pkg::CELL_MUL:
            begin
                r_next = r_lo ^ (ctl.a_bit & cs_reg);
            end
            gf2pa_pkg::CELL_SHIFT_UP:
            begin
                cs_next = cs_lo;
            end
            gf2pa_pkg::CELL_REDUCE:
            begin
                r_next  = r_reg ^ (ctl.t_bit & cs_reg);
                cs_next = cs_hi;
                q_next  = q_lo;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        cs_reg <= cs_next;
        q_reg  <= q_next;
    end

    assign r  = r_reg;
    assign cs = cs_reg;
    assign q  = q_reg;

endmodule

[hw/rtl/gf2pa_row.sv]
module gf2pa_row (
    input  logic                              clk,
    input  gf2pa_pkg::cell_ctl_t              ctl,
    input  logic [gf2pa_pkg::CELL_W-1:0]      ld_r,
    input  logic [gf2pa_pkg::CELL_W-1:0]      ld_cs,
    output logic [gf2pa_pkg::CELL_W-1:0]      r,
    output logic [gf2pa_pkg::CELL_W-1:0]      cs,
    output logic [gf2pa_pkg::CELL_W-1:0]      q
);

    logic [gf2pa_pkg::CELL_W-1:0] r_lo;
    logic [gf2pa_pkg::CELL_W-1:0] cs_lo;
    logic [gf2pa_pkg::CELL_W-1:0] cs_hi;
    logic [gf2pa_pkg::CELL_W-1:0] q_lo;

    // neighbor links; the quotient chain takes the new bit at the bottom
    assign r_lo  = {r[gf2pa_pkg::CELL_W-2:0], 1'b0};
    assign cs_lo = {cs[gf2pa_pkg::CELL_W-2:0], 1'b0};
    assign cs_hi = {1'b0, cs[gf2pa_pkg::CELL_W-1:1]};
    assign q_lo  = {q[gf2pa_pkg::CELL_W-2:0], ctl.t_bit};

    for (genvar i = 0; i < gf2pa_pkg::CELL_W; i++)
    begin : g_cell
        gf2pa_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .ld_r  (ld_r[i]),
            .ld_cs (ld_cs[i]),
            .r_lo  (r_lo[i]),
            .cs_lo (cs_lo[i]),
            .cs_hi (cs_hi[i]),
            .q_lo  (q_lo[i]),
            .r     (r[i]),
            .cs    (cs[i]),
            .q     (q[i])
        );
    end

endmodule

[hw/rtl/gf2_polynomial_alu.sv]
// The sequencer does one coefficient trim, align shift or reduce step per cycle.
// Throughput: one word at a time; busy stays high from accept to the result strobe.
// The result shows for one cycle on done; the receiver cannot stall it.
// Reset (rst_n, async low) returns the sequencer to idle and clears done.
`include "gf2_polynomial_alu_defines.svh"

module gf2_polynomial_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gf2pa_pkg::in_word_t   operand,
    output logic                  done,
    output gf2pa_pkg::out_word_t  result
);

    localparam int W  = gf2pa_pkg::CELL_W;
    localparam int LW = gf2pa_pkg::LEN_W;
    localparam int ML = gf2pa_pkg::MAX_LEN;

    gf2pa_pkg::state_t state_reg, state_next;
    gf2pa_pkg::src_t   src_reg, src_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [1:0]        status_reg, status_next;
    logic [ML-1:0]     a_reg, a_next;
    logic [ML-1:0]     b_reg, b_next;
    logic [ML-1:0]     c_reg, c_next;
    logic [LW-1:0]     lr_reg, lr_next;
    logic [LW-1:0]     lc_reg, lc_next;
    logic [LW-1:0]     p_reg, p_next;
    logic [LW-1:0]     qlen_reg, qlen_next;
    logic [LW-1:0]     ta_reg, ta_next;
    logic [LW-1:0]     tb_reg, tb_next;
    logic              done_reg, done_next;
    gf2pa_pkg::out_word_t out_reg, out_next;

    gf2pa_pkg::cell_ctl_t ctl;
    logic [W-1:0] ld_r, ld_cs, r_v, cs_v, q_v;

    logic [LW-1:0] la, lb, lb_m1, lr_m1, lc_m1;
    logic [ML-1:0] a_in, b_in;
    logic          b_top, r_top, c_top, t_bit, c_zero, r_zero;
    logic          r_trim, c_trim;

    assign la    = gf2pa_pkg::clamp_len(operand.first_len);
    assign lb    = gf2pa_pkg::clamp_len(operand.second_len);
    assign lb_m1 = lb - LW'(1);
    assign a_in  = operand.first_coeffs & gf2pa_pkg::len_mask(la);
    assign b_in  = operand.second_coeffs & gf2pa_pkg::len_mask(lb);
    assign b_top = b_in[lb_m1[4:0]];

    assign lr_m1  = lr_reg - LW'(1);
    assign lc_m1  = lc_reg - LW'(1);
    assign r_top  = r_v[lr_m1];
    assign c_top  = c_reg[lc_m1[4:0]];
    assign t_bit  = r_v[p_reg];
    assign c_zero = (lc_reg == LW'(1)) && !c_reg[0];
    assign r_zero = (lr_reg == LW'(1)) && !r_v[0];
    assign r_trim = (lr_reg > LW'(1)) && !r_top;
    assign c_trim = (lc_reg > LW'(1)) && !c_top;

    gf2pa_row u_row (
        .clk   (clk),
        .ctl   (ctl),
        .ld_r  (ld_r),
        .ld_cs (ld_cs),
        .r     (r_v),
        .cs    (cs_v),
        .q     (q_v)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gf2pa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (operand.command)
                        gf2pa_pkg::CMD_MUL: state_next = gf2pa_pkg::ST_MUL;
                        gf2pa_pkg::CMD_QUO,
                        gf2pa_pkg::CMD_REM:
                        begin
                            if (!b_top || (la < lb))
                                state_next = gf2pa_pkg::ST_FIN;
                            else
                                state_next = gf2pa_pkg::ST_ALIGN;
                        end
                        gf2pa_pkg::CMD_GCD,
                        gf2pa_pkg::CMD_LCM: state_next = gf2pa_pkg::ST_TRIM;
                        default:            state_next = gf2pa_pkg::ST_FIN;
                    endcase
                end
            end
            gf2pa_pkg::ST_TRIM:
            begin
                if (!r_trim && !c_trim)
                    state_next = gf2pa_pkg::ST_CHECK;
            end
            gf2pa_pkg::ST_CHECK:
            begin
                if (c_zero)
                begin
                    if ((cmd_reg == gf2pa_pkg::CMD_GCD) || r_zero)
                        state_next = gf2pa_pkg::ST_FIN;
                    else
                        state_next = gf2pa_pkg::ST_MUL;
                end
                else if (lr_reg < lc_reg)
                    state_next = gf2pa_pkg::ST_SWAP;
                else
                    state_next = gf2pa_pkg::ST_ALIGN;
            end
            gf2pa_pkg::ST_ALIGN:
            begin
                if (p_reg == lr_m1)
                    state_next = gf2pa_pkg::ST_REDUCE;
            end
            gf2pa_pkg::ST_REDUCE:
            begin
                if (p_reg == lc_m1)
                begin
                    if (cmd_reg == gf2pa_pkg::CMD_QUO)
                        state_next = gf2pa_pkg::ST_FIN;
                    else
                        state_next = gf2pa_pkg::ST_TRIMR;
                end
            end
            gf2pa_pkg::ST_TRIMR:
            begin
                if (!r_trim)
                begin
                    if (cmd_reg == gf2pa_pkg::CMD_REM)
                        state_next = gf2pa_pkg::ST_FIN;
                    else
                        state_next = gf2pa_pkg::ST_SWAP;
                end
            end
            gf2pa_pkg::ST_SWAP: state_next = gf2pa_pkg::ST_CHECK;
            gf2pa_pkg::ST_MUL:
            begin
                if (p_reg == '0)
                begin
                    if (cmd_reg == gf2pa_pkg::CMD_MUL)
                        state_next = gf2pa_pkg::ST_FIN;
                    else
                        state_next = gf2pa_pkg::ST_CHECK;
                end
            end
            gf2pa_pkg::ST_FIN:  state_next = gf2pa_pkg::ST_IDLE;
            default:            state_next = gf2pa_pkg::ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        src_next    = src_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        lr_next     = lr_reg;
        lc_next     = lc_reg;
        p_next      = p_reg;
        qlen_next   = qlen_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        done_next   = 1'b0;
        out_next    = out_reg;
        ctl.op      = gf2pa_pkg::CELL_HOLD;
        ctl.t_bit   = t_bit;
        ctl.a_bit   = a_reg[p_reg[4:0]];
        ld_r        = r_v;
        ld_cs       = cs_v;
        case (state_reg)
            gf2pa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = operand.command;
                    a_next      = a_in;
                    b_next      = b_in;
                    status_next = gf2pa_pkg::STAT_OK;
                    src_next    = gf2pa_pkg::SRC_ZERO;
                    case (operand.command)
                        gf2pa_pkg::CMD_MUL:
                        begin
                            ctl.op  = gf2pa_pkg::CELL_LOAD;
                            ld_r    = '0;
                            ld_cs   = W'(b_in);
                            p_next  = la - LW'(1);
                            ta_next = la;
                            lr_next = LW'({1'b0, la} + {1'b0, lb} - 7'd1);
                        end
                        gf2pa_pkg::CMD_QUO,
                        gf2pa_pkg::CMD_REM:
                        begin
                            if (!b_top)
                                status_next = gf2pa_pkg::STAT_DIV_TOP;
                            else if (la < lb)
                            begin
                                if (operand.command == gf2pa_pkg::CMD_QUO)
                                    status_next = gf2pa_pkg::STAT_SHORT;
                                else
                                begin
                                    ctl.op   = gf2pa_pkg::CELL_LOAD;
                                    ld_r     = W'(a_in);
                                    lr_next  = la;
                                    src_next = gf2pa_pkg::SRC_R;
                                end
                            end
                            else
                            begin
                                ctl.op  = gf2pa_pkg::CELL_LOAD;
                                ld_r    = W'(a_in);
                                ld_cs   = W'(b_in);
                                lr_next = la;
                                lc_next = lb;
                                c_next  = b_in;
                                p_next  = lb_m1;
                            end
                        end
                        gf2pa_pkg::CMD_GCD,
                        gf2pa_pkg::CMD_LCM:
                        begin
                            ctl.op  = gf2pa_pkg::CELL_LOAD;
                            ld_r    = W'(a_in);
                            lr_next = la;
                            lc_next = lb;
                            c_next  = b_in;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gf2pa_pkg::ST_TRIM:
            begin
                if (r_trim)
                    lr_next = lr_m1;
                if (c_trim)
                    lc_next = lc_m1;
                if (!r_trim && !c_trim)
                begin
                    ta_next = lr_reg;
                    tb_next = lc_reg;
                end
            end
            gf2pa_pkg::ST_CHECK:
            begin
                if (c_zero)
                begin
                    if (cmd_reg == gf2pa_pkg::CMD_GCD)
                        src_next = gf2pa_pkg::SRC_R;
                    else if (r_zero)
                        src_next = gf2pa_pkg::SRC_ZERO;
                    else
                    begin
                        // lcm: keep the gcd as divisor, then form the product
                        c_next  = r_v[ML-1:0];
                        lc_next = lr_reg;
                        ctl.op  = gf2pa_pkg::CELL_LOAD;
                        ld_r    = '0;
                        ld_cs   = W'(b_reg);
                        p_next  = ta_reg - LW'(1);
                        lr_next = LW'({1'b0, ta_reg} + {1'b0, tb_reg} - 7'd1);
                    end
                end
                else if (lr_reg >= lc_reg)
                begin
                    ctl.op = gf2pa_pkg::CELL_LOAD_CS;
                    ld_cs  = W'(c_reg);
                    p_next = lc_m1;
                end
            end
            gf2pa_pkg::ST_ALIGN:
            begin
                if (p_reg == lr_m1)
                    qlen_next = lr_reg - lc_reg + LW'(1);
                else
                begin
                    ctl.op = gf2pa_pkg::CELL_SHIFT_UP;
                    p_next = p_reg + LW'(1);
                end
            end
            gf2pa_pkg::ST_REDUCE:
            begin
                ctl.op = gf2pa_pkg::CELL_REDUCE;
                if (p_reg == lc_m1)
                begin
                    lr_next = (lc_reg == LW'(1)) ? LW'(1) : lc_m1;
                    if (cmd_reg == gf2pa_pkg::CMD_QUO)
                        src_next = gf2pa_pkg::SRC_Q;
                end
                else
                    p_next = p_reg - LW'(1);
            end
            gf2pa_pkg::ST_TRIMR:
            begin
                if (r_trim)
                    lr_next = lr_m1;
                else if (cmd_reg == gf2pa_pkg::CMD_REM)
                    src_next = gf2pa_pkg::SRC_R;
            end
            gf2pa_pkg::ST_SWAP:
            begin
                ctl.op  = gf2pa_pkg::CELL_LOAD;
                ld_r    = W'(c_reg);
                c_next  = r_v[ML-1:0];
                lr_next = lc_reg;
                lc_next = lr_reg;
            end
            gf2pa_pkg::ST_MUL:
            begin
                ctl.op = gf2pa_pkg::CELL_MUL;
                if (p_reg == '0)
                begin
                    if (cmd_reg == gf2pa_pkg::CMD_MUL)
                        src_next = gf2pa_pkg::SRC_R;
                    else
                        cmd_next = gf2pa_pkg::CMD_QUO;  // lcm goes on as product / gcd
                end
                else
                    p_next = p_reg - LW'(1);
            end
            gf2pa_pkg::ST_FIN:
            begin
                done_next       = 1'b1;
                out_next.status = status_reg;
                case (src_reg)
                    gf2pa_pkg::SRC_R:
                    begin
                        out_next.result_coeffs = r_v;
                        out_next.result_len    = lr_reg;
                    end
                    gf2pa_pkg::SRC_Q:
                    begin
                        out_next.result_coeffs = q_v;
                        out_next.result_len    = qlen_reg;
                    end
                    default:
                    begin
                        out_next.result_coeffs = '0;
                        out_next.result_len    = LW'(1);
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gf2pa_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        lr_reg     <= lr_next;
        lc_reg     <= lc_next;
        p_reg      <= p_next;
        qlen_reg   <= qlen_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        out_reg    <= out_next;
    end

    assign busy   = (state_reg != gf2pa_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = out_reg;

    `GF2PA_ASSERT_NEXT(a_fin_strobe, clk, rst_n, state_reg == gf2pa_pkg::ST_FIN, done)
    `GF2PA_ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    `GF2PA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `GF2PA_ASSERT_IMPLIES(a_len_nonzero, clk, rst_n, done, result.result_len != '0)

endmodule
